[rtl/core/aes128_pkg.sv]
// AES-128 package: S-box functions, round helpers and register indexes.
// Depends on nothing; used by the core, the checker and the testbench.
package aes128_pkg;

  localparam int unsigned NumRounds = 10;

  typedef enum logic [0:0] {
    CFG_KEY_HIGH = 1'b0,
    CFG_KEY_LOW  = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } opcode_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ x;
      x = xtime(x);
    end
    return p;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [255:0][7:0] t;
    t = {
      8'h16, 8'hbb, 8'h54, 8'hb0, 8'h0f, 8'h2d, 8'h99, 8'h41,
      8'h68, 8'h42, 8'he6, 8'hbf, 8'h0d, 8'h89, 8'ha1, 8'h8c,
      8'hdf, 8'h28, 8'h55, 8'hce, 8'he9, 8'h87, 8'h1e, 8'h9b,
      8'h94, 8'h8e, 8'hd9, 8'h69, 8'h11, 8'h98, 8'hf8, 8'he1,
      8'h9e, 8'h1d, 8'hc1, 8'h86, 8'hb9, 8'h57, 8'h35, 8'h61,
      8'h0e, 8'hf6, 8'h03, 8'h48, 8'h66, 8'hb5, 8'h3e, 8'h70,
      8'h8a, 8'h8b, 8'hbd, 8'h4b, 8'h1f, 8'h74, 8'hdd, 8'he8,
      8'hc6, 8'hb4, 8'ha6, 8'h1c, 8'h2e, 8'h25, 8'h78, 8'hba,
      8'h08, 8'hae, 8'h7a, 8'h65, 8'hea, 8'hf4, 8'h56, 8'h6c,
      8'ha9, 8'h4e, 8'hd5, 8'h8d, 8'h6d, 8'h37, 8'hc8, 8'he7,
      8'h79, 8'he4, 8'h95, 8'h91, 8'h62, 8'hac, 8'hd3, 8'hc2,
      8'h5c, 8'h24, 8'h06, 8'h49, 8'h0a, 8'h3a, 8'h32, 8'he0,
      8'hdb, 8'h0b, 8'h5e, 8'hde, 8'h14, 8'hb8, 8'hee, 8'h46,
      8'h88, 8'h90, 8'h2a, 8'h22, 8'hdc, 8'h4f, 8'h81, 8'h60,
      8'h73, 8'h19, 8'h5d, 8'h64, 8'h3d, 8'h7e, 8'ha7, 8'hc4,
      8'h17, 8'h44, 8'h97, 8'h5f, 8'hec, 8'h13, 8'h0c, 8'hcd,
      8'hd2, 8'hf3, 8'hff, 8'h10, 8'h21, 8'hda, 8'hb6, 8'hbc,
      8'hf5, 8'h38, 8'h9d, 8'h92, 8'h8f, 8'h40, 8'ha3, 8'h51,
      8'ha8, 8'h9f, 8'h3c, 8'h50, 8'h7f, 8'h02, 8'hf9, 8'h45,
      8'h85, 8'h33, 8'h4d, 8'h43, 8'hfb, 8'haa, 8'hef, 8'hd0,
      8'hcf, 8'h58, 8'h4c, 8'h4a, 8'h39, 8'hbe, 8'hcb, 8'h6a,
      8'h5b, 8'hb1, 8'hfc, 8'h20, 8'hed, 8'h00, 8'hd1, 8'h53,
      8'h84, 8'h2f, 8'he3, 8'h29, 8'hb3, 8'hd6, 8'h3b, 8'h52,
      8'ha0, 8'h5a, 8'h6e, 8'h1b, 8'h1a, 8'h2c, 8'h83, 8'h09,
      8'h75, 8'hb2, 8'h27, 8'heb, 8'he2, 8'h80, 8'h12, 8'h07,
      8'h9a, 8'h05, 8'h96, 8'h18, 8'hc3, 8'h23, 8'hc7, 8'h04,
      8'h15, 8'h31, 8'hd8, 8'h71, 8'hf1, 8'he5, 8'ha5, 8'h34,
      8'hcc, 8'hf7, 8'h3f, 8'h36, 8'h26, 8'h93, 8'hfd, 8'hb7,
      8'hc0, 8'h72, 8'ha4, 8'h9c, 8'haf, 8'ha2, 8'hd4, 8'had,
      8'hf0, 8'h47, 8'h59, 8'hfa, 8'h7d, 8'hc9, 8'h82, 8'hca,
      8'h76, 8'hab, 8'hd7, 8'hfe, 8'h2b, 8'h67, 8'h01, 8'h30,
      8'hc5, 8'h6f, 8'h6b, 8'hf2, 8'h7b, 8'h77, 8'h7c, 8'h63
    };
    return t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(8'(i)) == x) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // byte 0 at [127:120]; column c = bytes 4c..4c+3
  function automatic logic [7:0] get_b(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [127:0] t;
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = sbox(get_b(s, 4*((c+r)%4)+r));
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(t, 4*c); a1 = get_b(t, 4*c+1);
      a2 = get_b(t, 4*c+2); a3 = get_b(t, 4*c+3);
      m[127-32*c -: 32] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                           a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                           a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                           xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    end
    return last ? t : m;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] m;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_b(s, 4*c); a1 = get_b(s, 4*c+1);
      a2 = get_b(s, 4*c+2); a3 = get_b(s, 4*c+3);
      m[127-32*c -: 32] = {
        gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9),
        gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13),
        gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11),
        gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9) ^ gf_mul(a3, 8'd14)};
    end
    return m;
  endfunction

  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = inv_sbox(get_b(s, 4*((c-r+4)%4)+r));
    return t;
  endfunction

  function automatic logic [127:0] key_fwd(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    t = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] key_rev(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3;
    w3 = k[31:0] ^ k[63:32];
    w2 = k[63:32] ^ k[95:64];
    w1 = k[95:64] ^ k[127:96];
    w0 = k[127:96] ^ sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
    return {w0, w1, w2, w3};
  endfunction

endpackage

[rtl/core/aes128_if.sv]
// Valid/ready channel interfaces for the AES-128 core.
// Depends on nothing beyond the language.
interface aes128_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, opcode, block_high, block_low, input ready);
  modport sink (input valid, opcode, block_high, block_low, output ready);
endinterface

interface aes128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

interface aes128_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/aes128_block_cipher_core.sv]
// AES-128 round-iterative core: one shared round unit under a sequencer.
// Depends on aes128_pkg and the channel interfaces in aes128_if.sv.
//
//  channel | dir | payload                        | transfer
//  in      | in  | opcode, block_high, block_low  | valid & ready
//  out     | out | result_high, result_low        | valid & ready
//  cfg     | in  | index, data                    | valid & ready
//
// Encrypt: a load with the first key add, then the rounds, then the result is shown.
// Decrypt: the key schedule first runs forward to the last round key, then the rounds
// step the round key back. The shared round and key-step unit sets the rate.
// Reset clears control and the key registers; in.ready is low while busy and
// while a result waits; out stalls hold the result.
module aes128_block_cipher_core
  import aes128_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  aes128_in_if.sink    in_ch,
  aes128_out_if.source out_ch,
  aes128_cfg_if.sink   cfg_ch
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_KEXP  = 4'b0010,
    ST_ROUND = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t       state_r, state_nxt;
  logic [63:0]  key_high_r, key_low_r;
  logic [127:0] st_r, st_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic [3:0]   cnt_r, cnt_nxt;
  logic         dec_r, dec_nxt;
  logic [127:0] isr;
  logic [127:0] rk_prev;
  logic [7:0]   rc_prev;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state_r == ST_DONE);
  assign out_ch.result_high = st_r[127:64];
  assign out_ch.result_low  = st_r[63:0];

  assign isr     = inv_shift_sub(st_r);
  assign rc_prev = rc_r[0] ? {1'b1, rc_r[7:1] ^ 7'h0d} : {1'b0, rc_r[7:1]};
  assign rk_prev = key_rev(rk_r, rc_prev);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_KEY_HIGH: key_high_r <= cfg_ch.data;
        CFG_KEY_LOW:  key_low_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    rk_nxt    = rk_r;
    rc_nxt    = rc_r;
    cnt_nxt   = cnt_r;
    dec_nxt   = dec_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          st_nxt  = {in_ch.block_high, in_ch.block_low};
          rk_nxt  = {key_high_r, key_low_r};
          rc_nxt  = 8'h01;
          cnt_nxt = '0;
          dec_nxt = in_ch.opcode;
          if (opcode_t'(in_ch.opcode) == OP_DECRYPT) begin
            state_nxt = ST_KEXP;
          end else begin
            st_nxt    = {in_ch.block_high, in_ch.block_low} ^ {key_high_r, key_low_r};
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_KEXP: begin
        rk_nxt  = key_fwd(rk_r, rc_r);
        rc_nxt  = xtime(rc_r);
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(NumRounds - 1)) begin
          st_nxt    = st_r ^ key_fwd(rk_r, rc_r);
          cnt_nxt   = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cnt_nxt = cnt_r + 4'd1;
        if (!dec_r) begin
          rk_nxt = key_fwd(rk_r, rc_r);
          rc_nxt = xtime(rc_r);
          st_nxt = enc_round(st_r, cnt_r == 4'(NumRounds - 1)) ^ key_fwd(rk_r, rc_r);
        end else begin
          rk_nxt = rk_prev;
          rc_nxt = rc_prev;
          st_nxt = (cnt_r == 4'(NumRounds - 1)) ? (isr ^ rk_prev)
                                                 : inv_mix(isr ^ rk_prev);
        end
        if (cnt_r == 4'(NumRounds - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dec_r   <= dec_nxt;
    end
    st_r <= st_nxt;
    rk_r <= rk_nxt;
    rc_r <= rc_nxt;
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(st_r) && out_ch.valid)
    else $error("result changed under stall");
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND && cnt_r == 4'(NumRounds - 1) |=> state_r == ST_DONE)
    else $error("round count overrun");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ch.ready)
    else $error("ready while busy");

endmodule

[tb/aes128_cipher_checker.sv]
// Checker for the AES-128 core: watches the key, block and result transfers,
// computes each expected block and compares it. Depends on aes128_pkg and the
// channel interfaces.
module aes128_cipher_checker
  import aes128_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  aes128_in_if  in_ch,
  aes128_out_if out_ch,
  aes128_cfg_if cfg_ch,
  output int    mismatches,
  output int    pending
);

  typedef logic [7:0] state_t [16];

  logic [7:0]   sb_fwd [256];
  logic [7:0]   sb_inv [256];
  logic [63:0]  cipher_key_high;
  logic [63:0]  cipher_key_low;
  logic [127:0] expected_blocks [$];

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] base;
    r = 8'h01;
    base = x;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) r = gmul(r, base);
      base = gmul(base, base);
    end
    return r;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] v, input int n);
    return 8'((v << n) | (v >> (8 - n)));
  endfunction

  initial begin
    logic [7:0] b;
    for (int i = 0; i < 256; i++) begin
      b = ginv(8'(i));
      sb_fwd[i] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
    end
    for (int i = 0; i < 256; i++) sb_inv[sb_fwd[i]] = 8'(i);
  end

  function automatic state_t shift_rows(input state_t s, input logic inverse);
    state_t t;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = inverse ? ((c - r + 4) % 4) : ((c + r) % 4);
        t[c*4+r] = s[src*4+r];
      end
    return t;
  endfunction

  function automatic state_t mix_columns(input state_t s, input logic inverse);
    state_t t;
    logic [7:0] m [4];
    logic [7:0] acc;
    if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        acc = 8'h00;
        for (int k = 0; k < 4; k++) acc = acc ^ gmul(m[(k - r + 4) % 4], s[c*4+k]);
        t[c*4+r] = acc;
      end
    return t;
  endfunction

  function automatic logic [127:0] aes128_transform(input opcode_t op,
                                                    input logic [127:0] blk);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0]  rc;
    logic [7:0]  rk [11][16];
    state_t      st;
    logic [127:0] res;
    w[0] = cipher_key_high[63:32];
    w[1] = cipher_key_high[31:0];
    w[2] = cipher_key_low[63:32];
    w[3] = cipher_key_low[31:0];
    rc = 8'h01;
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sb_fwd[t[31:24]], sb_fwd[t[23:16]], sb_fwd[t[15:8]], sb_fwd[t[7:0]]};
        t = t ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++)
      for (int c = 0; c < 4; c++)
        for (int b = 0; b < 4; b++) rk[r][c*4+b] = w[r*4+c][31-8*b -: 8];
    for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
    if (op == OP_ENCRYPT) begin
      for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[0][i];
      for (int r = 1; r <= 10; r++) begin
        for (int i = 0; i < 16; i++) st[i] = sb_fwd[st[i]];
        st = shift_rows(st, 1'b0);
        if (r < 10) st = mix_columns(st, 1'b0);
        for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[r][i];
      end
    end else begin
      for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[10][i];
      for (int r = 9; r >= 0; r--) begin
        st = shift_rows(st, 1'b1);
        for (int i = 0; i < 16; i++) st[i] = sb_inv[st[i]] ^ rk[r][i];
        if (r > 0) st = mix_columns(st, 1'b1);
      end
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  assign pending = expected_blocks.size();

  always @(posedge clk) begin
    logic [127:0] want;
    if (!rst_n) begin
      cipher_key_high <= '0;
      cipher_key_low  <= '0;
      expected_blocks.delete();
      mismatches <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_KEY_HIGH) cipher_key_high <= cfg_ch.data;
        else cipher_key_low <= cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready)
        expected_blocks.push_back(aes128_transform(opcode_t'(in_ch.opcode),
                                                   {in_ch.block_high, in_ch.block_low}));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result %h_%h", $time,
                   out_ch.result_high, out_ch.result_low);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (out_ch.result_high !== want[127:64]) begin
            $display("%0t: result_high expected %h actual %h", $time,
                     want[127:64], out_ch.result_high);
            mismatches <= mismatches + 1;
          end else if (out_ch.result_low !== want[63:0]) begin
            $display("%0t: result_low expected %h actual %h", $time,
                     want[63:0], out_ch.result_low);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule

[tb/tb.sv]
// Top of the AES-128 core testbench: clock, reset, key writes, block stimulus
// and verdict. Depends on aes128_pkg, the channel interfaces, the core and the checker.
module tb;
  import aes128_pkg::*;

  localparam int StallLimit = 5000;

  logic clk;
  logic rst_n;
  logic calm;
  int   mismatches;
  int   pending;
  int   idle_cycles;
  int   stall_left;
  int   n_enc;
  int   n_dec;
  int   n_keys;

  aes128_in_if  in_if ();
  aes128_out_if out_if ();
  aes128_cfg_if cfg_if ();

  aes128_block_cipher_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  aes128_cipher_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_if),
    .out_ch     (out_if),
    .cfg_ch     (cfg_if),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left <= 0;
    end else if (calm) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_if.ready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, StallLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_block(input opcode_t op, input logic [63:0] hi, input logic [63:0] lo);
    gap();
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.block_high <= hi;
    in_if.block_low  <= lo;
    do @(posedge clk); while (!in_if.ready);
    if (op == OP_ENCRYPT) n_enc++;
    else n_dec++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0 || out_if.valid);
  endtask

  task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_KEY_HIGH;
    cfg_if.data  <= hi;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= CFG_KEY_LOW;
    cfg_if.data  <= lo;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    n_keys++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic random_blocks(input int count);
    logic [63:0] hi;
    logic [63:0] lo;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 7))
        0: begin hi = '0; lo = rand64(); end
        1: begin hi = '1; lo = '1; end
        default: begin hi = rand64(); lo = rand64(); end
      endcase
      send_block(opcode_t'($urandom_range(0, 1)), hi, lo);
    end
  endtask

  initial begin
    calm = 1'b0;
    rst_n = 1'b0;
    n_enc = 0;
    n_dec = 0;
    n_keys = 0;
    in_if.valid <= 1'b0;
    in_if.opcode <= OP_ENCRYPT;
    in_if.block_high <= '0;
    in_if.block_low <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_KEY_HIGH;
    cfg_if.data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero key from reset
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '1);
    write_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(OP_ENCRYPT, '0, '1);
    send_block(OP_DECRYPT, '1, '0);
    write_key('1, '1);
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '0, '0);
    send_block(OP_ENCRYPT, 64'h8000000000000000, 64'h0000000000000001);
    send_block(OP_DECRYPT, 64'h8000000000000000, 64'h0000000000000001);
    write_key('0, '1);
    send_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(OP_DECRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);

    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        3: write_key('0, '0);
        6: write_key('1, '0);
        default: write_key(rand64(), rand64());
      endcase
      random_blocks(140);
    end
    drain();
    calm = 1'b1;
    write_key(rand64(), rand64());
    random_blocks(130);
    drain();
    repeat (30) @(posedge clk);

    $display("Covered %0d encrypt and %0d decrypt blocks under %0d key settings,",
             n_enc, n_dec, n_keys + 1);
    $display("with random sender gaps and result stalls, then a stall-free stretch.");
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
